/* src/cdq_pkg.sv */
// cdq_pkg: sizes, codes, state type and word helpers for the circular deque
// depends on nothing; every other file of the block uses it
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

	// store geometry
	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;

	// derived widths
	localparam int PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = 16;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;
	localparam int DATA_W = 32;
	localparam int BITC_W = $clog2(IDX_W + 1);
	localparam int WIDE_W = WORD_BITS + DATA_W;

	typedef logic [PTR_W-1:0]     ptr_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [WORD_BITS-1:0] word_t;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_READ       = 3'd3,
		OP_CLEAR      = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ADDR,
		ST_DATA
	} state_t;

	// ring slot at base plus offset, both below capacity
	function automatic ptr_t slot_add(ptr_t base, ptr_t off);
		logic [PTR_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (PTR_W+1)'(CAPACITY)) begin
			s = s - (PTR_W+1)'(CAPACITY);
		end
		return s[PTR_W-1:0];
	endfunction

	// ring slot just before base
	function automatic ptr_t slot_dec(ptr_t base);
		ptr_t r;
		if (base == '0) begin
			r = PTR_W'(CAPACITY - 1);
		end else begin
			r = base - ptr_t'(1);
		end
		return r;
	endfunction

	// sign-extended input word cut to the stored width
	function automatic word_t to_word(logic signed [DATA_W-1:0] v);
		logic signed [WIDE_W-1:0] w;
		w = WIDE_W'(v);
		return w[WORD_BITS-1:0];
	endfunction

	// stored word sign-extended, low bits returned
	function automatic logic [DATA_W-1:0] from_word(word_t w);
		logic signed [WIDE_W-1:0] x;
		x = WIDE_W'(signed'(w));
		return x[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/cdq_ifs.sv */
// cdq_req_if and cdq_rsp_if: valid/ready channels of the circular deque
// depends on cdq_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface cdq_req_if;
	logic                                valid;
	logic                                ready;
	logic [cdq_pkg::OP_W-1:0]            op;
	logic signed [cdq_pkg::DATA_W-1:0]   value;
	logic [cdq_pkg::IDX_W-1:0]           index;

	modport source (output valid, output op, output value, output index, input ready);
	modport sink   (input valid, input op, input value, input index, output ready);
endinterface

interface cdq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [cdq_pkg::ST_W-1:0]            status;
	logic signed [cdq_pkg::DATA_W-1:0]   read_value;

	modport source (output valid, output status, output read_value, input ready);
	modport sink   (input valid, input status, input read_value, output ready);
endinterface

`default_nettype wire

/* src/cdq_mod_unit.sv */
// cdq_mod_unit: bit-serial restoring remainder of the read index by the count
// depends on cdq_pkg; one dividend bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module cdq_mod_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [cdq_pkg::IDX_W-1:0] dividend,
	input  wire logic [cdq_pkg::CNT_W-1:0] divisor,
	output logic                           done,
	output logic [cdq_pkg::PTR_W-1:0]      remainder
);
	import cdq_pkg::*;

	logic                busy_q;
	logic [BITC_W-1:0]   bits_q;
	logic [IDX_W-1:0]    dvd_q;
	cnt_t                dvs_q;
	cnt_t                rem_q;
	logic [CNT_W:0]      trial;
	logic [CNT_W:0]      diff;
	cnt_t                rem_next;

	// one restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, dvd_q[IDX_W-1]};
		diff  = trial - {1'b0, dvs_q};
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = diff[CNT_W-1:0];
		end else begin
			rem_next = trial[CNT_W-1:0];
		end
	end

	assign done      = busy_q && (bits_q == BITC_W'(1));
	assign remainder = rem_q[PTR_W-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bits_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			bits_q <= BITC_W'(IDX_W);
		end else if (busy_q) begin
			bits_q <= bits_q - BITC_W'(1);
			if (bits_q == BITC_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[IDX_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

endmodule

`default_nettype wire

/* src/circular_deque_with_indexed_read_top.sv */
// Circular deque of signed words with indexed read. Each request beat carries one
// operation (push front, push back, pop front, read at index, clear) and yields
// exactly one response beat with a status and a read value. Push, pop, clear and
// reads of an empty list finish in the cycle they are accepted. A read of a
// non-empty list passes through the bit-serial remainder of the 16-bit index by the
// entry count in the modulo unit, then addresses the ring memory, then loads its
// registered read data into the output register, waiting while that register is
// not free. The sequencer takes no new request until it has loaded that response
// and is back in idle. The request side accepts only in idle, and there also while
// a finished response waits in the output register, as long as that register is
// being drained or empty. A push into a full list is dropped with status full.
// Depends on cdq_pkg, cdq_ifs and cdq_mod_unit.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_with_indexed_read_top (
	input  wire logic clk,
	input  wire logic arst_n,
	cdq_req_if.sink   req,
	cdq_rsp_if.source rsp
);
	import cdq_pkg::*;

	state_t state_q, state_d;

	ptr_t  front_q;
	cnt_t  count_q;

	// ring memory
	word_t ring_mem [CAPACITY];
	word_t rd_data_q;
	logic  mem_we;
	ptr_t  mem_waddr;
	word_t mem_wdata;
	logic  mem_re;
	ptr_t  mem_raddr;

	// output register
	logic                     out_valid_q;
	logic [ST_W-1:0]          out_status_q;
	logic [DATA_W-1:0]        out_value_q;
	logic                     out_free;
	logic                     out_load;
	status_t                  load_status;
	logic [DATA_W-1:0]        load_value;

	logic  accept;
	logic  div_start;
	logic  div_done;
	ptr_t  div_rem;
	ptr_t  front_d;
	cnt_t  count_d;
	logic  is_full;
	logic  is_empty;

	assign out_free = !out_valid_q || rsp.ready;
	assign accept   = req.valid && req.ready;
	assign is_full  = (count_q >= CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	// modulo unit for the read index
	cdq_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (req.index),
		.divisor   (count_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// sequencer next state and outputs
	always_comb begin
		state_d     = state_q;
		req.ready   = 1'b0;
		front_d     = front_q;
		count_d     = count_q;
		mem_we      = 1'b0;
		mem_waddr   = front_q;
		mem_wdata   = to_word(req.value);
		mem_re      = 1'b0;
		mem_raddr   = slot_add(front_q, div_rem);
		div_start   = 1'b0;
		out_load    = 1'b0;
		load_status = STS_OK;
		load_value  = '0;
		case (state_q)
			ST_IDLE: begin
				req.ready = out_free;
				if (req.valid && out_free) begin
					case (req.op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							out_load = 1'b1;
							if (is_full) begin
								load_status = STS_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + CNT_W'(1);
								if (req.op == OP_PUSH_FRONT) begin
									front_d   = slot_dec(front_q);
									mem_waddr = slot_dec(front_q);
								end else begin
									mem_waddr = slot_add(front_q, count_q[PTR_W-1:0]);
								end
							end
						end
						OP_POP_FRONT: begin
							out_load = 1'b1;
							if (is_empty) begin
								load_status = STS_EMPTY;
							end else begin
								front_d = slot_add(front_q, ptr_t'(1));
								count_d = count_q - CNT_W'(1);
							end
						end
						OP_READ: begin
							if (is_empty) begin
								out_load    = 1'b1;
								load_status = STS_EMPTY;
							end else begin
								div_start = 1'b1;
								state_d   = ST_DIV;
							end
						end
						OP_CLEAR: begin
							out_load = 1'b1;
							front_d  = '0;
							count_d  = '0;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				mem_re  = 1'b1;
				state_d = ST_DATA;
			end
			ST_DATA: begin
				if (out_free) begin
					out_load   = 1'b1;
					load_value = from_word(rd_data_q);
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				front_q <= front_d;
				count_q <= count_d;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= load_status;
			out_value_q  <= load_value;
		end
	end

	// ring memory write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= ring_mem[mem_raddr];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_value_q;

endmodule

`default_nettype wire

/* test/circular_deque_with_indexed_read_top_tb.sv */
// circular_deque_with_indexed_read_top_tb: self-checking bench for the circular deque
// drives request beats with random gaps and stalls, predicts every response and compares
// depends on cdq_pkg, cdq_ifs and the circular_deque_with_indexed_read_top RTL
`timescale 1ns / 1ps

module circular_deque_with_indexed_read_top_tb;
	import cdq_pkg::*;

	localparam int ITEMS_PER_PHASE = 500;
	localparam int HOLD_CYCLES     = 400;
	localparam int STALL_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int REPORT_MAX      = 10;

	typedef struct packed {
		status_t                status;
		logic [DATA_W-1:0]      read_value;
	} deque_result_t;

	// tracks deque contents and the responses still owed by the block
	class deque_tracker;
		word_t           ring [CAPACITY];
		ptr_t            front;
		cnt_t            count;
		deque_result_t   owed [$];
		int              mismatches;
		int              checked;
		int              reads_ok;
		int              empty_hits;
		int              full_drops;

		function new();
			front = '0;
			count = '0;
			mismatches = 0;
			checked = 0;
			reads_ok = 0;
			empty_hits = 0;
			full_drops = 0;
		endfunction

		// input word cut to stored width, sign carried when wider
		function word_t narrow(logic signed [DATA_W-1:0] v);
			logic signed [WORD_BITS+DATA_W-1:0] w;
			w = v;
			return w[WORD_BITS-1:0];
		endfunction

		// stored word sign-extended back to the output width
		function logic [DATA_W-1:0] widen(word_t w);
			logic signed [WORD_BITS+DATA_W-1:0] x;
			x = signed'(w);
			return x[DATA_W-1:0];
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// apply one accepted request beat and queue its response
		function void accept_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
			logic [IDX_W-1:0] index);
			deque_result_t r;
			int            slot;
			r.status = STS_OK;
			r.read_value = '0;
			case (op)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (int'(count) >= CAPACITY) begin
						r.status = STS_FULL;
						full_drops++;
					end else begin
						if (op == OP_PUSH_FRONT) begin
							front = ptr_t'((int'(front) + CAPACITY - 1) % CAPACITY);
							slot = int'(front);
						end else begin
							slot = (int'(front) + int'(count)) % CAPACITY;
						end
						ring[slot] = narrow(value);
						count = count + cnt_t'(1);
					end
				end
				OP_POP_FRONT: begin
					if (count == '0) begin
						r.status = STS_EMPTY;
						empty_hits++;
					end else begin
						front = ptr_t'((int'(front) + 1) % CAPACITY);
						count = count - cnt_t'(1);
					end
				end
				OP_READ: begin
					if (count == '0) begin
						r.status = STS_EMPTY;
						empty_hits++;
					end else begin
						slot = (int'(front) + int'(index) % int'(count)) % CAPACITY;
						r.read_value = widen(ring[slot]);
						reads_ok++;
					end
				end
				OP_CLEAR: begin
					front = '0;
					count = '0;
				end
				// unused codes leave the state alone
				default: ;
			endcase
			owed.push_back(r);
		endfunction

		// compare one response beat with the oldest owed result
		function void check_response(logic [ST_W-1:0] status, logic [DATA_W-1:0] value);
			deque_result_t e;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: response with none owed: status %0d value %h",
						$realtime, status, value);
				return;
			end
			e = owed.pop_front();
			checked++;
			if (status !== e.status || value !== e.read_value) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: response %0d: status exp %0d got %0d, value exp %h got %h",
						$realtime, checked, e.status, status, e.read_value, value);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cdq_req_if req_ch ();
	cdq_rsp_if rsp_ch ();

	circular_deque_with_indexed_read_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deque_tracker tracker = new();

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_request;
	int  holds_done;
	int  items_sent;
	int  ignored_sent;
	int  stall_cycles;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without a beat", stall_cycles);
				$display("end of test: mismatches");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// response side: random stalls, one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				holds_done++;
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				tracker.check_response(rsp_ch.status, rsp_ch.read_value);
		end
	end

	// offer one request beat after random gaps and wait for it to be taken
	task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
		input logic [IDX_W-1:0] index);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.value <= value;
		req_ch.index <= index;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		tracker.accept_request(op, value, index);
		if (op <= OP_CLEAR)
			items_sent++;
		else
			ignored_sent++;
	endtask

	// random word, often an extreme
	function automatic logic [DATA_W-1:0] pick_word();
		logic [DATA_W-1:0] w;
		case ($urandom_range(7))
			0: w = {1'b1, {(DATA_W-1){1'b0}}};
			1: w = {1'b0, {(DATA_W-1){1'b1}}};
			2: w = '0;
			3: w = '1;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// index at most twice the capacity or anywhere in range
	function automatic logic [IDX_W-1:0] pick_index();
		logic [IDX_W-1:0] i;
		if ($urandom_range(1))
			i = IDX_W'($urandom_range(2 * CAPACITY));
		else
			i = IDX_W'($urandom_range(65535));
		return i;
	endfunction

	task automatic push_any();
		send_beat($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word(), pick_index());
	endtask

	// one random sequence: fill, drain, reads, mixed traffic or noise
	task automatic run_sequence();
		int n;
		case ($urandom_range(9))
			0, 1, 2: begin
				n = CAPACITY - int'(tracker.count) + $urandom_range(1, 3);
				repeat (n) push_any();
			end
			3, 4: begin
				n = int'(tracker.count) + $urandom_range(1, 2);
				repeat (n) send_beat(OP_POP_FRONT, pick_word(), pick_index());
			end
			5, 6, 7: begin
				n = $urandom_range(2, 6);
				repeat (n) send_beat(OP_READ, pick_word(), pick_index());
			end
			8: begin
				n = $urandom_range(3, 10);
				repeat (n) send_beat(OP_W'($urandom_range(OP_READ)), pick_word(), pick_index());
			end
			default: begin
				if ($urandom_range(1))
					send_beat(OP_CLEAR, pick_word(), pick_index());
				else
					send_beat(OP_W'($urandom_range(7)), pick_word(), pick_index());
			end
		endcase
	endtask

	task automatic run_phase(input int sender_pct, input int receiver_pct);
		int target;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		target = items_sent + ITEMS_PER_PHASE;
		while (items_sent < target) run_sequence();
	endtask

	// directed corners: empty list, extremes, wrap, unused codes, clear
	task automatic run_directed();
		send_beat(OP_POP_FRONT, '0, '0);
		send_beat(OP_READ, '0, '0);
		send_beat(OP_READ, '1, '1);
		send_beat(OP_PUSH_FRONT, 32'h8000_0000, '0);
		send_beat(OP_PUSH_BACK, 32'h7fff_ffff, '1);
		send_beat(OP_PUSH_FRONT, '0, '0);
		send_beat(OP_PUSH_BACK, '1, '0);
		send_beat(OP_READ, '0, 16'd0);
		send_beat(OP_READ, '0, 16'd3);
		send_beat(OP_READ, '0, 16'd4);
		send_beat(OP_READ, '0, 16'hffff);
		send_beat(OP_READ, '0, 16'h5555);
		send_beat(OP_POP_FRONT, '0, '0);
		send_beat(OP_READ, '0, 16'd0);
		send_beat(OP_W'(5), '1, '1);
		send_beat(OP_W'(6), '1, '1);
		send_beat(OP_W'(7), '1, '1);
		send_beat(OP_READ, '0, 16'd2);
		send_beat(OP_CLEAR, '1, '1);
		send_beat(OP_READ, '0, 16'd0);
		send_beat(OP_POP_FRONT, '0, '0);
		send_beat(OP_PUSH_BACK, 32'h5a5a_5a5a, '0);
		send_beat(OP_READ, '0, 16'd0);
		send_beat(OP_READ, '0, 16'hffff);
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op    <= '0;
		req_ch.value <= '0;
		req_ch.index <= '0;
		hold_request = 1'b0;
		holds_done = 0;
		items_sent = 0;
		ignored_sent = 0;
		stall_cycles = 0;
		send_idle_pct = 23;
		recv_idle_pct = 50;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_phase(23, 50);
		run_phase(50, 23);
		// back-to-back traffic, receiver holds off first so the block backs up
		hold_request = 1'b1;
		run_phase(0, 0);
		req_ch.valid <= 1'b0;

		// let the owed responses come back, then watch for strays
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d request beats (%0d with unused codes), %0d responses checked",
			items_sent + ignored_sent, ignored_sent, tracker.checked);
		$display("%0d indexed reads, %0d empty-list results, %0d dropped pushes, %0d hold-offs",
			tracker.reads_ok, tracker.empty_hits, tracker.full_drops, holds_done);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", tracker.mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* files.f */
src/cdq_pkg.sv
src/cdq_ifs.sv
src/cdq_mod_unit.sv
src/circular_deque_with_indexed_read_top.sv
test/circular_deque_with_indexed_read_top_tb.sv
